// ===== sv/sha1_hash_engine_top_assert.svh =====
// Assertion macros shared by the SHA-1 engine RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SHA1_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA1_HASH_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_AST_IMP(lbl, ck, rn, lhs, rhs) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (lhs) |-> (rhs)) \
		else $error("sha1 check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHA1_AST_NXT(lbl, ck, rn, lhs, rhs) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (lhs) |=> (rhs)) \
		else $error("sha1 check failed");

`endif

// ===== sv/sha1_pkg.sv =====
// Types, constants and helper functions for the SHA-1 engine.
// No dependencies; imported by the controller, datapath and top level.
package sha1_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [6:0] LAST_ROUND    = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [2:0] LAST_LEN_BYTE = 3'd7;
	localparam logic [5:0] CNT_FULL      = 6'd63;
	localparam logic [5:0] CNT_PAD_END   = 6'd56;
	localparam logic [7:0] PAD_BYTE      = 8'h80;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic       shift_en;
		byte_src_t  src;
		logic [2:0] len_sel;
		logic       len_inc;
		logic       comp_load;
		logic       comp_round;
		logic       comp_add;
		logic [6:0] round;
		logic       reinit;
		logic       dig_load;
		logic       dig_shift;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_full;
		logic cnt_pad_end;
	} dp_stat_t;

	function automatic logic [31:0] round_const(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = 32'h5A827999;
		end else if (r < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (r < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_fn(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r >= 7'd40 && r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage

// ===== sv/sha1_dp.sv =====
// SHA-1 datapath: block shift register doubling as message schedule, round
// registers, chaining words, bit length and digest output buffer. Uses sha1_pkg.
module sha1_dp import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [7:0]  data_byte,
	output dp_stat_t    stat,
	output logic [31:0] digest_word
);

	logic [511:0] blk_q;
	logic [5:0]   cnt_q;
	logic [63:0]  len_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [31:0]  dig_q [5];

	logic [7:0]   byte_in;
	logic [31:0]  w0, w2, w8, w13, w_mix, w_new, t_sum;

	always_comb begin
		unique case (cmd.src)
			SRC_DATA: byte_in = data_byte;
			SRC_PAD:  byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN:  byte_in = len_q[{~cmd.len_sel, 3'b000} +: 8];
		endcase
	end

	// Window word j sits at blk_q[511-32j -: 32]; word 0 is the current round's.
	assign w0    = blk_q[511:480];
	assign w2    = blk_q[447:416];
	assign w8    = blk_q[255:224];
	assign w13   = blk_q[95:64];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[30:0], w_mix[31]};

	assign t_sum = {a_q[26:0], a_q[31:27]} + round_fn(cmd.round, b_q, c_q, d_q)
		+ e_q + w0 + round_const(cmd.round);

	// Block buffer and round registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.comp_round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.comp_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.comp_round) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.dig_load) begin
			for (int i = 0; i < 5; i++) begin
				dig_q[i] <= h_q[i];
			end
		end else if (cmd.dig_shift) begin
			for (int i = 0; i < 4; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.reinit) begin
				cnt_q <= '0;
				len_q <= '0;
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end else begin
				if (cmd.shift_en) begin
					cnt_q <= cnt_q + 6'd1;
				end
				if (cmd.len_inc) begin
					len_q <= len_q + 64'd8;
				end
				if (cmd.comp_add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
			end
		end
	end

	assign stat.cnt_full    = (cnt_q == CNT_FULL);
	assign stat.cnt_pad_end = (cnt_q == CNT_PAD_END);
	assign digest_word      = dig_q[0];

endmodule

// ===== sv/sha1_ctrl.sv =====
// SHA-1 controller: sequences absorb, padding, 80 compression rounds and
// digest output. Uses sha1_pkg and sha1_hash_engine_top_assert.svh.
`include "sha1_hash_engine_top_assert.svh"
module sha1_ctrl import sha1_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       msg_valid,
	input  logic       msg_mode,
	output logic       msg_ready,
	output logic       dig_valid,
	input  logic       dig_ready,
	output logic [2:0] word_index,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [6:0] round_q;
	logic [2:0] len_idx_q;
	logic       fin_q;
	logic       len_done_q;
	logic       out_valid_q;
	logic [2:0] out_idx_q;

	logic       msg_acc;
	logic       dig_acc;

	assign msg_ready  = (state_q == ST_IDLE);
	assign msg_acc    = msg_valid && msg_ready;
	assign dig_valid  = out_valid_q;
	assign dig_acc    = out_valid_q && dig_ready;
	assign word_index = out_idx_q;

	always_comb begin
		cmd           = '0;
		cmd.src       = SRC_DATA;
		cmd.round     = round_q;
		cmd.len_sel   = len_idx_q;
		cmd.dig_shift = dig_acc;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_acc && msg_mode == MODE_ABSORB) begin
					cmd.shift_en = 1'b1;
					cmd.len_inc  = 1'b1;
				end
			end
			ST_PAD80: begin
				cmd.shift_en = 1'b1;
				cmd.src      = SRC_PAD;
			end
			ST_PADZ: begin
				if (!stat.cnt_pad_end) begin
					cmd.shift_en = 1'b1;
					cmd.src      = SRC_ZERO;
				end
			end
			ST_PADLEN: begin
				cmd.shift_en = 1'b1;
				cmd.src      = SRC_LEN;
			end
			ST_LOAD:  cmd.comp_load  = 1'b1;
			ST_ROUND: cmd.comp_round = 1'b1;
			ST_ADD:   cmd.comp_add   = 1'b1;
			ST_EMIT: begin
				if (!out_valid_q) begin
					cmd.dig_load = 1'b1;
					cmd.reinit   = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			len_idx_q   <= '0;
			fin_q       <= 1'b0;
			len_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (dig_acc) begin
				if (out_idx_q == LAST_WORD_IDX) begin
					out_valid_q <= 1'b0;
				end else begin
					out_idx_q <= out_idx_q + 3'd1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg_mode == MODE_FINISH) begin
							fin_q      <= 1'b1;
							len_done_q <= 1'b0;
							state_q    <= ST_PAD80;
						end else if (stat.cnt_full) begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PAD80: begin
					state_q <= stat.cnt_full ? ST_LOAD : ST_PADZ;
				end
				ST_PADZ: begin
					if (stat.cnt_pad_end) begin
						len_idx_q <= '0;
						state_q   <= ST_PADLEN;
					end else if (stat.cnt_full) begin
						state_q <= ST_LOAD;
					end
				end
				ST_PADLEN: begin
					len_idx_q <= len_idx_q + 3'd1;
					if (len_idx_q == LAST_LEN_BYTE) begin
						len_done_q <= 1'b1;
						state_q    <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					priority if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_done_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PADZ;
					end
				end
				ST_EMIT: begin
					// hold until the previous digest has drained
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= '0;
						fin_q       <= 1'b0;
						len_done_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`SHA1_AST_NXT(a_round_end, clk, arst_n, state_q == ST_ROUND && round_q == LAST_ROUND, state_q == ST_ADD)
	`SHA1_AST_NXT(a_emit_load, clk, arst_n, state_q == ST_EMIT && !out_valid_q, out_valid_q && out_idx_q == 3'd0 && state_q == ST_IDLE)
	`SHA1_AST_IMP(a_idx_range, clk, arst_n, out_valid_q, out_idx_q <= LAST_WORD_IDX)
	`SHA1_AST_NXT(a_last_drop, clk, arst_n, dig_acc && out_idx_q == LAST_WORD_IDX, !out_valid_q)

endmodule

// ===== sv/sha1_hash_engine_top.sv =====
// SHA-1 engine top level. An absorb item shifts in one byte; a full block then
// takes load, 80 rounds of one round unit and add. A finish item pads one or two
// blocks before the first digest word, then five words at one per cycle while
// dig_ready is high. Input is accepted while an earlier digest is still being read.
// Reset restores initial chaining words, zero length and an empty output.
module sha1_hash_engine_top import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_item_t dig
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] digest_word;
	logic [2:0]  word_index;

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_mode   (msg.mode),
		.msg_ready  (msg_ready),
		.dig_valid  (dig_valid),
		.dig_ready  (dig_ready),
		.word_index (word_index),
		.stat       (stat),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign dig.digest_word = digest_word;
	assign dig.word_index  = word_index;
	assign dig.last_word   = (word_index == LAST_WORD_IDX);

endmodule

// ===== tb/sha1_hash_engine_checker.sv =====
// Scoreboard for the SHA-1 engine: watches both channels, predicts digest words
// from the accepted message items and compares every accepted digest word.
// Depends on sha1_pkg for the item types, mode codes and initial hash words.
module sha1_hash_engine_checker import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	input  logic        msg_ready,
	input  msg_item_t   msg,
	input  logic        dig_valid,
	input  logic        dig_ready,
	input  dig_item_t   dig,
	output int unsigned pending = 0,
	output int unsigned fail_count = 0
);

	logic [7:0]  msg_block [64];
	logic [5:0]  fill;
	logic [63:0] bit_len;
	logic [31:0] chain_h [5];
	dig_item_t   expected_words [$];
	int unsigned errs = 0;

	task automatic restart_hash();
		foreach (chain_h[i]) begin
			chain_h[i] = H_INIT[i];
		end
		fill = '0;
		bit_len = '0;
	endtask

	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] data);
		msg_block[fill] = data;
		bit_len += 64'd8;
		fill += 6'd1;
		// fill wrapped: the block just became full
		if (fill == '0) begin
			sha1_compress();
		end
	endtask

	task automatic finish_message();
		int pos;
		dig_item_t word;
		pos = fill;
		msg_block[pos] = PAD_BYTE;
		pos++;
		// no room for the length: pad out and spill into a second block
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			sha1_compress();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++) begin
			msg_block[56+i] = bit_len[63-8*i -: 8];
		end
		sha1_compress();
		for (int i = 0; i < 5; i++) begin
			word.digest_word = chain_h[i];
			word.word_index = 3'(i);
			word.last_word = (word.word_index == LAST_WORD_IDX);
			expected_words.push_back(word);
		end
		restart_hash();
	endtask

	always @(posedge clk or negedge arst_n) begin
		dig_item_t want;
		if (!arst_n) begin
			restart_hash();
			expected_words.delete();
		end else begin
			if (dig_valid && dig_ready) begin
				if (expected_words.size() == 0) begin
					$error("digest item %h arrived with nothing expected", dig);
					errs++;
				end else begin
					want = expected_words.pop_front();
					if (dig.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h", want.digest_word,
							dig.digest_word);
						errs++;
					end
					if (dig.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d", want.word_index,
							dig.word_index);
						errs++;
					end
					if (dig.last_word !== want.last_word) begin
						$error("last_word: expected %b, got %b", want.last_word,
							dig.last_word);
						errs++;
					end
				end
			end
			if (msg_valid && msg_ready) begin
				if (msg.mode == MODE_FINISH) begin
					finish_message();
				end else begin
					absorb_byte(msg.data_byte);
				end
			end
		end
		pending <= expected_words.size();
		fail_count <= errs;
	end

endmodule

// ===== tb/sha1_hash_engine_top_tb.sv =====
// Testbench top for the SHA-1 engine: drives message items, throttles the digest
// channel and reports the verdict. Depends on sha1_pkg, the engine top level and
// sha1_hash_engine_checker, which predicts and compares the digest words.
module sha1_hash_engine_top_tb import sha1_pkg::*;;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEM_GOAL   = 280;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_ready;
	msg_item_t msg = '0;
	logic      dig_valid;
	logic      dig_ready = 1'b0;
	dig_item_t dig;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned snd_idle = 37;
	int unsigned rcv_idle = 66;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned msg_count = 0;
	int unsigned msg_len = 0;
	int unsigned longest = 0;

	sha1_hash_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	sha1_hash_engine_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_ready  (dig_ready),
		.dig        (dig),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		dig_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sha1_hash_engine_top_tb: done, errors");
			$finish;
		end
	end

	task automatic push_item(input logic m, input logic [7:0] b);
		while ($urandom_range(99) < snd_idle) begin
			msg_valid <= 1'b0;
			@(posedge clk);
		end
		msg_valid <= 1'b1;
		msg.mode <= m;
		msg.data_byte <= b;
		@(posedge clk);
		while (!msg_ready) begin
			@(posedge clk);
		end
		items_sent++;
		if (m == MODE_FINISH) begin
			msg_count++;
			if (msg_len > longest) begin
				longest = msg_len;
			end
			msg_len = 0;
		end else begin
			msg_len++;
		end
	endtask

	// Hold the sender off until every predicted digest word has been read.
	task automatic wait_drained();
		msg_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int unsigned boundary_len [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		int unsigned len;
		int unsigned phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then "abc", then extreme bytes, then back-to-back finishes
		push_item(MODE_FINISH, 8'h00);
		push_item(MODE_ABSORB, 8'h61);
		push_item(MODE_ABSORB, 8'h62);
		push_item(MODE_ABSORB, 8'h63);
		push_item(MODE_FINISH, 8'hFF);
		push_item(MODE_ABSORB, 8'h00);
		push_item(MODE_ABSORB, 8'hFF);
		push_item(MODE_FINISH, 8'hFF);
		push_item(MODE_FINISH, 8'hA5);
		push_item(MODE_FINISH, 8'h5A);
		wait_drained();

		while (items_sent < ITEM_GOAL || msg_count < 12) begin
			if (phase == 0 && items_sent >= 100) begin
				phase = 1;
				wait_drained();
				snd_idle = 66;
				rcv_idle = 37;
			end else if (phase == 1 && items_sent >= 190) begin
				phase = 2;
				wait_drained();
				snd_idle = 0;
				rcv_idle = 0;
			end
			case ($urandom_range(7))
				0, 1, 2, 3: len = $urandom_range(8);
				4, 5:       len = boundary_len[$urandom_range(8)];
				default:    len = $urandom_range(70, 9);
			endcase
			for (int unsigned j = 0; j < len; j++) begin
				push_item(MODE_ABSORB, 8'($urandom_range(255)));
			end
			push_item(MODE_FINISH, 8'($urandom_range(255)));
		end

		wait_drained();
		repeat (300) @(posedge clk);
		$display("%0d items, %0d messages (longest %0d bytes), three throttle mixes",
			items_sent, msg_count, longest);
		$display("%0d digest words predicted and compared", msg_count * 5);
		if (fail_count == 0) begin
			$display("sha1_hash_engine_top_tb: done, clean");
		end else begin
			$display("sha1_hash_engine_top_tb: done, errors");
		end
		$finish;
	end

endmodule
